// File: hdl/bod_pkg.sv
`default_nettype none

package bod_pkg;

  localparam int MAX_ROW_BYTES = 512;
  localparam int LANES         = 8;
  localparam int COL_W         = 9;
  localparam int ROW_W         = 3;
  localparam int ROWLEN_W      = 10;
  localparam int WIDTH_W       = 13;
  localparam int PCT_W         = 8;
  localparam int THR_W         = 8;
  localparam int BAYER_W       = 6;
  localparam int PIX_W         = 8;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DARKNESS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_BYTES = 2'd3;

  localparam logic MODE_SHADE = 1'b0;
  localparam logic MODE_FADE  = 1'b1;

  // percent * 64 / 100 as a multiply by 2^14 * 0.64, exact for all 8-bit inputs
  localparam int THR_SHIFT = 14;
  localparam int THR_RECIP = 10486;
  localparam int THR_PROD_W = PCT_W + THR_SHIFT;

  localparam logic [BAYER_W-1:0] BAYER [8][8] = '{
    '{6'd0,  6'd48, 6'd12, 6'd60, 6'd3,  6'd51, 6'd15, 6'd63},
    '{6'd32, 6'd16, 6'd44, 6'd28, 6'd35, 6'd19, 6'd47, 6'd31},
    '{6'd8,  6'd56, 6'd4,  6'd52, 6'd11, 6'd59, 6'd7,  6'd55},
    '{6'd40, 6'd24, 6'd36, 6'd20, 6'd43, 6'd27, 6'd39, 6'd23},
    '{6'd2,  6'd50, 6'd14, 6'd62, 6'd1,  6'd49, 6'd13, 6'd61},
    '{6'd34, 6'd18, 6'd46, 6'd30, 6'd33, 6'd17, 6'd45, 6'd29},
    '{6'd10, 6'd58, 6'd6,  6'd54, 6'd9,  6'd57, 6'd5,  6'd53},
    '{6'd42, 6'd26, 6'd38, 6'd22, 6'd41, 6'd25, 6'd37, 6'd21}
  };

  typedef struct packed {
    logic                mode;
    logic [THR_W-1:0]    thr;
    logic [WIDTH_W-1:0]  width;
    logic [ROWLEN_W-1:0] row_len;
  } bod_cfg_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } bod_pos_t;

  function automatic logic [THR_W-1:0] pct_to_thr(input logic [PCT_W-1:0] pct);
    logic [THR_PROD_W-1:0] prod;
    prod = THR_PROD_W'(pct) * THR_PROD_W'(THR_RECIP);
    return prod[THR_SHIFT +: THR_W];
  endfunction

endpackage

`default_nettype wire

// File: hdl/bod_if.sv
`default_nettype none

interface bod_in_if import bod_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] data_byte;
  logic [PIX_W-1:0] mask_byte;
  logic             first_of_image;

  modport source (output valid, output data_byte, output mask_byte, output first_of_image,
                  input ready);
  modport sink   (input valid, input data_byte, input mask_byte, input first_of_image,
                  output ready);
endinterface

interface bod_out_if import bod_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] data_out;
  logic [PIX_W-1:0] mask_out;

  modport source (output valid, output data_out, output mask_out, input ready);
  modport sink   (input valid, input data_out, input mask_out, output ready);
endinterface

interface bod_cfg_if import bod_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/bod_cfg.sv
`default_nettype none

module bod_cfg import bod_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  bod_cfg_if.sink   cfg,
  output bod_cfg_t  cfg_q
);

  logic                mode_r, mode_nxt;
  logic [THR_W-1:0]    thr_r, thr_nxt;
  logic [WIDTH_W-1:0]  width_r, width_nxt;
  logic [ROWLEN_W-1:0] row_len_r, row_len_nxt;
  logic [ROWLEN_W-1:0] row_raw;
  logic [ROWLEN_W-1:0] row_clamped;

  assign cfg.ready = 1'b1;

  assign row_raw = cfg.data[ROWLEN_W-1:0];

  always_comb begin
    if (row_raw == '0) begin
      row_clamped = ROWLEN_W'(1);
    end else if (row_raw > ROWLEN_W'(MAX_ROW_BYTES)) begin
      row_clamped = ROWLEN_W'(MAX_ROW_BYTES);
    end else begin
      row_clamped = row_raw;
    end
  end

  always_comb begin
    mode_nxt    = mode_r;
    thr_nxt     = thr_r;
    width_nxt   = width_r;
    row_len_nxt = row_len_r;
    if (cfg.valid) begin
      unique case (cfg.index)
        CFG_MODE:      mode_nxt    = cfg.data[0];
        CFG_DARKNESS:  thr_nxt     = pct_to_thr(cfg.data[PCT_W-1:0]);
        CFG_WIDTH:     width_nxt   = cfg.data[WIDTH_W-1:0];
        CFG_ROW_BYTES: row_len_nxt = row_clamped;
        default:       mode_nxt    = mode_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_SHADE;
      thr_r     <= '0;
      width_r   <= WIDTH_W'(8);
      row_len_r <= ROWLEN_W'(1);
    end else begin
      mode_r    <= mode_nxt;
      thr_r     <= thr_nxt;
      width_r   <= width_nxt;
      row_len_r <= row_len_nxt;
    end
  end

  assign cfg_q.mode    = mode_r;
  assign cfg_q.thr     = thr_r;
  assign cfg_q.width   = width_r;
  assign cfg_q.row_len = row_len_r;

endmodule

`default_nettype wire

// File: hdl/bod_pos.sv
`default_nettype none

module bod_pos import bod_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  logic                first,
  input  logic [ROWLEN_W-1:0] row_len,
  output bod_pos_t            cur
);

  logic [COL_W-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [ROWLEN_W-1:0] col_inc;

  always_comb begin
    if (first) begin
      cur.col = '0;
      cur.row = '0;
    end else begin
      cur.col = col_r;
      cur.row = row_r;
    end
  end

  assign col_inc = ROWLEN_W'(cur.col) + ROWLEN_W'(1);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (advance) begin
      if (col_inc >= row_len) begin
        col_nxt = '0;
        row_nxt = cur.row + ROW_W'(1);
      end else begin
        col_nxt = col_inc[COL_W-1:0];
        row_nxt = cur.row;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/bod_lane.sv
`default_nettype none

module bod_lane import bod_pkg::*; (
  input  logic [2:0]         lane,
  input  bod_pos_t           pos,
  input  logic [THR_W-1:0]   thr,
  input  logic [WIDTH_W-1:0] width,
  output logic               hit
);

  logic [BAYER_W-1:0] entry;
  logic [COL_W+2:0]   x;

  assign entry = BAYER[pos.row][lane];
  assign x     = {pos.col, lane};
  assign hit   = (WIDTH_W'(x) < width) && (THR_W'(entry) < thr);

endmodule

`default_nettype wire

// File: hdl/bod_merge.sv
`default_nettype none

module bod_merge import bod_pkg::*; (
  input  logic             mode,
  input  logic [PIX_W-1:0] data_in,
  input  logic [PIX_W-1:0] mask_in,
  input  logic [LANES-1:0] hit,
  output logic [PIX_W-1:0] data_out,
  output logic [PIX_W-1:0] mask_out
);

  always_comb begin
    if (mode == MODE_FADE) begin
      data_out = '0;
      mask_out = mask_in | hit;
    end else begin
      data_out = data_in & ~hit;
      mask_out = mask_in;
    end
  end

endmodule

`default_nettype wire

// File: hdl/bayer_ordered_dither_shade.sv
// Ordered 8x8 dither of a 1-bit-per-pixel frame, one packed byte per word.
// in_ch carries data_byte (bit 7 leftmost pixel), mask_byte and first_of_image,
// which restarts the position at column 0, row 0 for that word.
// out_ch carries data_out and mask_out, one word for every input word, in order.
// cfg_ch writes mode (0), darkness_percent (1), width_pixels (2) and
// row_bytes (3); it is always ready. Write it only while no word is in flight.
// Eight pixel lanes look up their Bayer entries in parallel against the
// threshold held with the configuration, and a merge stage applies the mode.
// An accepted word is registered and presented on out_ch in the cycle after acceptance.
// Throughput: one word per cycle while the receiver keeps ready high; the single output register sets the rate.
// When the receiver stalls, the output word holds and in_ch.ready drops until
// the word is taken; ready stays high while the output register is empty or
// being drained.
// Reset (rst_n low, synchronous) empties the output register, returns the
// position to column 0, row 0 and loads shade mode, darkness 0, width 8 and
// one byte per row.
`default_nettype none

module bayer_ordered_dither_shade import bod_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  bod_in_if.sink    in_ch,
  bod_out_if.source out_ch,
  bod_cfg_if.sink   cfg_ch
);

  bod_cfg_t         cfg_q;
  bod_pos_t         pos;
  logic [LANES-1:0] hit;
  logic [PIX_W-1:0] data_m;
  logic [PIX_W-1:0] mask_m;
  logic             in_ready;
  logic             in_fire;
  logic             out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0] data_r, data_nxt;
  logic [PIX_W-1:0] mask_r, mask_nxt;

  assign in_ready    = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  bod_cfg u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_ch),
    .cfg_q (cfg_q)
  );

  bod_pos u_pos (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (in_fire),
    .first   (in_ch.first_of_image),
    .row_len (cfg_q.row_len),
    .cur     (pos)
  );

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    bod_lane u_lane (
      .lane  (3'(i)),
      .pos   (pos),
      .thr   (cfg_q.thr),
      .width (cfg_q.width),
      .hit   (hit[LANES-1-i])
    );
  end

  bod_merge u_merge (
    .mode     (cfg_q.mode),
    .data_in  (in_ch.data_byte),
    .mask_in  (in_ch.mask_byte),
    .hit      (hit),
    .data_out (data_m),
    .mask_out (mask_m)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    data_nxt      = data_r;
    mask_nxt      = mask_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
      data_nxt      = data_m;
      mask_nxt      = mask_m;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    mask_r <= mask_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.data_out = data_r;
  assign out_ch.mask_out = mask_r;

endmodule

`default_nettype wire

// File: hdl/bod_checker.sv
`default_nettype none

module bod_checker import bod_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [PIX_W-1:0] out_data,
  input  logic [PIX_W-1:0] out_mask
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output word present after reset");

  a_accept_shows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted word not presented next cycle");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled while output can drain");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data) && $stable(out_mask))
    else $error("stalled output word changed");

endmodule

bind bayer_ordered_dither_shade bod_checker u_bod_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data_out),
  .out_mask  (out_ch.mask_out)
);

`default_nettype wire

// File: dv/tb.sv
`default_nettype none

module tb;
  import bod_pkg::*;

  localparam int unsigned LIMIT = 200000;
  localparam int unsigned LONG_HOLD = 300;

  localparam bit [5:0] bayer_rank [8][8] = '{
    '{0, 48, 12, 60, 3, 51, 15, 63},
    '{32, 16, 44, 28, 35, 19, 47, 31},
    '{8, 56, 4, 52, 11, 59, 7, 55},
    '{40, 24, 36, 20, 43, 27, 39, 23},
    '{2, 50, 14, 62, 1, 49, 13, 61},
    '{34, 18, 46, 30, 33, 17, 45, 29},
    '{10, 58, 6, 54, 9, 57, 5, 53},
    '{42, 26, 38, 22, 41, 25, 37, 21}
  };

  typedef struct packed {
    logic [PIX_W-1:0] data;
    logic [PIX_W-1:0] mask;
    logic             first;
  } pix_byte_t;

  typedef struct packed {
    logic [PIX_W-1:0] data;
    logic [PIX_W-1:0] mask;
  } shaded_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_COMB, RX_SPARSE} rx_style_t;

  logic clk;
  logic rst_n;

  bod_in_if  in_ch ();
  bod_out_if out_ch ();
  bod_cfg_if cfg_ch ();

  bayer_ordered_dither_shade uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  pix_byte_t byte_queue [$];
  shaded_t   shaded_queue [$];
  bit        word_loaded = 1'b0;
  int        burst_left = 1;
  int        gap_left = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  logic                dith_mode  = MODE_SHADE;
  logic [PCT_W-1:0]    dith_pct   = '0;
  logic [WIDTH_W-1:0]  dith_width = WIDTH_W'(8);
  logic [ROWLEN_W-1:0] dith_rowb  = ROWLEN_W'(1);
  int unsigned         dith_col   = 0;
  logic [ROW_W-1:0]    dith_row   = '0;

  rx_style_t   rx_style = RX_OPEN;
  int unsigned rx_tick = 0;
  int unsigned rx_hold = 0;
  bit          hold_arm = 1'b0;
  bit          hold_done = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin : feed
    int unsigned      thr;
    int unsigned      rl;
    logic [PIX_W-1:0] hit;
    logic [PIX_W-1:0] d;
    logic [PIX_W-1:0] m;
    pix_byte_t        w;
    if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        CFG_MODE:      dith_mode  = cfg_ch.data[0];
        CFG_DARKNESS:  dith_pct   = cfg_ch.data[PCT_W-1:0];
        CFG_WIDTH:     dith_width = cfg_ch.data[WIDTH_W-1:0];
        CFG_ROW_BYTES: dith_rowb  = cfg_ch.data[ROWLEN_W-1:0];
        default: ;
      endcase
    end
    if (in_ch.valid && in_ch.ready) begin
      word_loaded = 1'b0;
      if (in_ch.first_of_image) begin
        dith_col = 0;
        dith_row = '0;
      end
      thr = (int'(dith_pct) * 64) / 100;
      hit = '0;
      for (int b = 0; b < LANES; b++)
        if (dith_col * 8 + b < dith_width && bayer_rank[dith_row][b] < thr)
          hit[LANES-1-b] = 1'b1;
      d = in_ch.data_byte;
      m = in_ch.mask_byte;
      if (dith_mode == MODE_FADE) begin
        d = '0;
        m = m | hit;
      end else begin
        d = d & ~hit;
      end
      shaded_queue.push_back('{data: d, mask: m});
      rl = (dith_rowb == 0) ? 1 : (dith_rowb > MAX_ROW_BYTES) ? MAX_ROW_BYTES : dith_rowb;
      dith_col++;
      if (dith_col >= rl) begin
        dith_col = 0;
        dith_row = dith_row + 1'b1;
      end
    end
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (byte_queue.size() != 0) begin
        w = byte_queue.pop_front();
        word_loaded = 1'b1;
        in_ch.data_byte      <= w.data;
        in_ch.mask_byte      <= w.mask;
        in_ch.first_of_image <= w.first;
        in_ch.valid          <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 8);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    rx_tick++;
    if (rx_tick % 32 == 0)
      rx_style = rx_style_t'($urandom_range(0, 3));
    if (rx_hold > 0) begin
      rx_hold--;
      out_ch.ready <= 1'b0;
    end else if (hold_arm && !hold_done) begin
      hold_done = 1'b1;
      rx_hold = LONG_HOLD;
      out_ch.ready <= 1'b0;
    end else begin
      case (rx_style)
        RX_OPEN: out_ch.ready <= 1'b1;
        RX_COIN: out_ch.ready <= 1'($urandom_range(0, 1));
        RX_COMB: out_ch.ready <= (rx_tick % 4 != 3);
        default: out_ch.ready <= ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  always @(posedge clk) begin : check
    shaded_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (shaded_queue.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected word: data %02h mask %02h", out_ch.data_out, out_ch.mask_out);
        mismatches++;
      end else begin
        want = shaded_queue.pop_front();
        if (want.data != out_ch.data_out || want.mask != out_ch.mask_out) begin
          if (mismatches < 10)
            $display("mismatch: expected data %02h mask %02h, got data %02h mask %02h",
                     want.data, want.mask, out_ch.data_out, out_ch.mask_out);
          mismatches++;
        end
      end
    end
  end

  task automatic add_byte(input logic [PIX_W-1:0] d, input logic [PIX_W-1:0] m,
                          input logic f);
    byte_queue.push_back('{data: d, mask: m, first: f});
  endtask

  task automatic wait_idle();
    while (byte_queue.size() != 0 || word_loaded || shaded_queue.size() != 0)
      @(posedge clk);
  endtask

  task automatic program_regs(input logic md, input int unsigned pct,
                              input int unsigned wd, input int unsigned rb);
    logic [CFG_IDX_W-1:0]  idx [4];
    logic [CFG_DATA_W-1:0] val [4];
    idx = '{CFG_MODE, CFG_DARKNESS, CFG_WIDTH, CFG_ROW_BYTES};
    val = '{CFG_DATA_W'(md), CFG_DATA_W'(pct), CFG_DATA_W'(wd), CFG_DATA_W'(rb)};
    for (int i = 0; i < 4; i++) begin
      cfg_ch.index <= idx[i];
      cfg_ch.data  <= val[i];
      cfg_ch.valid <= 1'b1;
      do @(posedge clk); while (!cfg_ch.ready);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [PIX_W-1:0] pick_byte();
    case ($urandom_range(0, 5))
      0:       return '1;
      1:       return '0;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    int unsigned rb;
    int unsigned rl;
    int unsigned wd;
    int unsigned pc;
    int unsigned left;
    logic        md;
    logic        f;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.mask_byte = '0;
    in_ch.first_of_image = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    add_byte(8'hFF, 8'h00, 1'b1);
    add_byte(8'h00, 8'hFF, 1'b0);
    add_byte(8'hA5, 8'h3C, 1'b0);
    wait_idle();

    program_regs(MODE_SHADE, 50, 8, 1);
    for (int r = 0; r < 8; r++)
      add_byte(8'hFF, 8'h5A, r == 0);
    wait_idle();

    program_regs(MODE_FADE, 255, 13, 3);
    for (int i = 0; i < 4; i++)
      add_byte(8'hFF, 8'h00, i == 0);
    wait_idle();

    // shrink the row while the column sits past the new end
    program_regs(MODE_FADE, 255, 13, 1);
    add_byte(8'hC3, 8'h81, 1'b0);
    add_byte(8'hFF, 8'h00, 1'b0);
    wait_idle();

    program_regs(MODE_SHADE, 255, 0, 0);
    add_byte(8'hFF, 8'h00, 1'b1);
    add_byte(8'hFF, 8'hFF, 1'b0);
    wait_idle();

    program_regs(MODE_SHADE, 100, 4096, 1000);
    for (int i = 0; i < 3; i++)
      add_byte(8'hFF, 8'h0F, i == 0);
    wait_idle();

    program_regs(MODE_SHADE, 73, 4096, 512);
    for (int i = 0; i < 130; i++)
      add_byte(pick_byte(), pick_byte(), i == 0);
    wait_idle();

    left = 0;
    for (int ph = 0; ph < 12; ph++) begin
      md = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 5))
        0:       pc = 0;
        1:       pc = 100;
        2:       pc = 255;
        default: pc = $urandom_range(0, 255);
      endcase
      case ($urandom_range(0, 5))
        0:       rb = 0;
        1:       rb = $urandom_range(600, 1023);
        2:       rb = $urandom_range(20, 40);
        default: rb = $urandom_range(1, 8);
      endcase
      rl = (rb == 0) ? 1 : (rb > MAX_ROW_BYTES) ? MAX_ROW_BYTES : rb;
      case ($urandom_range(0, 5))
        0:       wd = 0;
        1:       wd = 8191;
        2:       wd = 4096;
        default: wd = $urandom_range(1, rl * 8 + 8);
      endcase
      program_regs(md, pc, wd, rb);
      if (ph == 3)
        hold_arm = 1'b1;
      for (int i = 0; i < 20; i++) begin
        f = 1'b0;
        if (left == 0) begin
          left = rl * $urandom_range(1, 3);
          if ($urandom_range(0, 3) == 0)
            left = $urandom_range(1, left);
          f = 1'b1;
        end else if ($urandom_range(0, 19) == 0) begin
          f = 1'b1;
        end
        left--;
        add_byte(pick_byte(), pick_byte(), f);
      end
      wait_idle();
    end

    repeat (4) @(posedge clk);
    if (mismatches == 0 && shaded_queue.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire
